### design/fbl_pkg.sv
// Shared types, constants and codes for the framebuffer line rasterizer.
`timescale 1ns / 1ps

package fbl_pkg;

   // Field widths
   localparam int COORD_W   = 10;
   localparam int COLOUR_W  = 16;
   localparam int ADDR_W    = 32;
   localparam int REQ_W     = 4 * COORD_W + COLOUR_W;
   localparam int RSP_W     = ADDR_W + COLOUR_W;

   // Divider operand widths: |dx| * |dy| fits in 20 bits
   localparam int NUM_W     = 2 * COORD_W;
   localparam int DEN_W     = COORD_W;

   // Parameter defaults
   localparam int SCREEN_WIDTH_DEF = 480;
   localparam int PIXEL_BYTES_DEF  = 2;
   localparam int QUEUE_DEPTH_DEF  = 2;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_BASE = 2'd0;

   // Request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Line sweep phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_VERT,
      PH_HORZ,
      PH_GENX,
      PH_GENY
   } phase_type;

   // Back-end sequencer state
   typedef enum logic [2:0] {
      BK_WAIT,
      BK_SETUP,
      BK_DIV,
      BK_COORD,
      BK_EMIT
   } bk_state_type;

   // Classified command held in the queue
   typedef struct packed {
      logic                opcode;
      phase_type           phase;
      logic [COORD_W-1:0]  step;
      logic [COORD_W-1:0]  x_start;
      logic [COORD_W-1:0]  y_start;
      logic [COORD_W-1:0]  x_end;
      logic [COORD_W-1:0]  y_end;
      logic [COLOUR_W-1:0] colour;
   } fbl_cmd_type;

endpackage

### design/framebuffer_line_rasterizer.sv
// Top level of the framebuffer line rasterizer: front end, queue, back end, CSR.
`timescale 1ns / 1ps

// A load beat (tuser = 0) stores two endpoints and a colour and starts a new
// line; each tick beat (tuser = 1) then yields one pixel write beat carrying
// the byte address frame_base + ((SCREEN_WIDTH - x) + y * SCREEN_WIDTH) *
// PIXEL_BYTES and the colour, with tlast on the final pixel. Ticks with no
// line in progress produce nothing. The front end takes one beat per cycle,
// while the queue has room, into a QUEUE_DEPTH-entry command queue; the back
// end drains it one command at a time. A load sets the line state, a tick
// on a vertical or horizontal line goes straight out, and a tick on a sloped
// line runs the 20-step radix-2 divider that interpolates the dependent
// coordinate. A finished pixel sits in an output register, so the back end
// keeps working while it waits to be taken. No clearing pass follows reset.
module framebuffer_line_rasterizer import fbl_pkg::*; #(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,   // 1 to 1024
   parameter int PIXEL_BYTES  = PIXEL_BYTES_DEF,    // 1 to 4
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF     // 2 or more
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // x_start, y_start, x_end, y_end, pen_colour
   input  logic                  req_tuser,   // opcode
   // pixel write stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // pixel_address, pixel_colour
   output logic                  rsp_tlast,   // last_pixel
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [ADDR_W-1:0] frame_base_ff;
   logic              queue_full, push, pop, not_empty;
   fbl_cmd_type       push_cmd, pop_cmd;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FRAME_BASE) ? frame_base_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == CSR_FRAME_BASE) begin
         frame_base_ff <= csr_pwdata;
      end
   end

   fbl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   fbl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .not_empty (not_empty)
   );

   fbl_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .PIXEL_BYTES  (PIXEL_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pop_cmd),
      .cmd_valid  (not_empty),
      .cmd_pop    (pop),
      .frame_base (frame_base_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/fbl_front.sv
// Front end: accepts request beats and classifies line commands.
`timescale 1ns / 1ps

module fbl_front import fbl_pkg::*; (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // x_start, y_start, x_end, y_end, pen_colour
   input  logic             req_tuser,   // opcode
   input  logic             queue_full,
   output logic             push,
   output fbl_cmd_type      cmd
);

   logic [COORD_W-1:0] x0, y0, xn, yn;

   assign x0 = req_tdata[COORD_W-1:0];
   assign y0 = req_tdata[2*COORD_W-1:COORD_W];
   assign xn = req_tdata[3*COORD_W-1:2*COORD_W];
   assign yn = req_tdata[4*COORD_W-1:3*COORD_W];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Pick the sweep kind and its starting coordinate
   always_comb begin
      cmd.opcode  = req_tuser;
      cmd.x_start = x0;
      cmd.y_start = y0;
      cmd.x_end   = xn;
      cmd.y_end   = yn;
      cmd.colour  = req_tdata[REQ_W-1:4*COORD_W];
      if (req_tuser == OP_TICK) begin
         cmd.phase = PH_IDLE;
         cmd.step  = '0;
      end else if (x0 == xn) begin
         cmd.phase = PH_VERT;
         cmd.step  = (y0 < yn) ? y0 : yn;
      end else if (y0 == yn) begin
         cmd.phase = PH_HORZ;
         cmd.step  = (x0 < xn) ? x0 : xn;
      end else begin
         cmd.phase = PH_GENX;
         cmd.step  = (x0 < xn) ? x0 : xn;
      end
   end

endmodule

### design/fbl_queue.sv
// Short command queue between front and back end.
`timescale 1ns / 1ps

module fbl_queue import fbl_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF   // 2 or more
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fbl_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output fbl_cmd_type pop_data,
   output logic        not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   fbl_cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/fbl_divider.sv
// Radix-2 restoring divider, unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module fbl_divider import fbl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W:0]     shifted;
   logic [DEN_W+1:0]   trial;

   // One restoring step: shift in the next dividend bit, try subtract
   // (the remainder stays below the divisor, so it fits in DEN_W bits)
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         if (trial[DEN_W+1]) begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/fbl_back.sv
// Back end: line state, per-pixel interpolation and the result register.
`timescale 1ns / 1ps

module fbl_back import fbl_pkg::*; #(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int PIXEL_BYTES  = PIXEL_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fbl_cmd_type       cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  logic [ADDR_W-1:0] frame_base,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast
);

   localparam logic [ADDR_W-1:0] SCREEN_W32 = ADDR_W'(SCREEN_WIDTH);
   localparam logic [ADDR_W-1:0] PIXEL_B32  = ADDR_W'(PIXEL_BYTES);

   bk_state_type state_ff, state_in;

   // Line state
   phase_type            phase_ff;
   logic [COORD_W-1:0]   step_ff;
   logic [COORD_W-1:0]   x0_ff, y0_ff, xn_ff, yn_ff;
   logic [COLOUR_W-1:0]  colour_ff;

   // Current pixel
   logic [COORD_W-1:0]   px_ff, py_ff;
   logic                 last_ff;
   logic                 solve_x_ff;     // sloped line, y sweep: x is interpolated
   logic                 quo_neg_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [COLOUR_W-1:0]  rsp_colour_ff;
   logic                 rsp_last_ff;

   logic                 is_tick, is_straight, is_general, out_free, div_start, load_out;
   logic [COORD_W-1:0]   x_hi, y_hi, y_lo, sweep_top;
   logic                 at_top;
   logic signed [COORD_W:0]     pos_diff, dnum, dden;
   logic signed [2*COORD_W+1:0] prod;
   logic [2*COORD_W+1:0]        prod_mag;
   logic [COORD_W:0]            den_mag;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quo;
   logic [COORD_W+1:0]          q_signed, coord_sum;
   logic [COORD_W-1:0]          coord_base;
   logic [ADDR_W-1:0]           pix_offset, pix_addr;

   assign is_tick     = (cmd.opcode == OP_TICK);
   assign is_straight = (phase_ff == PH_VERT) || (phase_ff == PH_HORZ);
   assign is_general  = (phase_ff == PH_GENX) || (phase_ff == PH_GENY);
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_WAIT: begin
            if (cmd_valid && is_tick && is_straight) begin
               state_in = BK_EMIT;
            end else if (cmd_valid && is_tick && is_general) begin
               state_in = BK_SETUP;
            end
         end
         BK_SETUP: state_in = BK_DIV;
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_COORD;
            end
         end
         BK_COORD: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_WAIT;
            end
         end
         default: state_in = BK_WAIT;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_pop   = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BK_WAIT:  cmd_pop   = cmd_valid;
         BK_SETUP: div_start = 1'b1;
         BK_EMIT:  load_out  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sweep limits
   assign x_hi      = (x0_ff > xn_ff) ? x0_ff : xn_ff;
   assign y_hi      = (y0_ff > yn_ff) ? y0_ff : yn_ff;
   assign y_lo      = (y0_ff < yn_ff) ? y0_ff : yn_ff;
   assign sweep_top = ((phase_ff == PH_VERT) || (phase_ff == PH_GENY)) ? y_hi : x_hi;
   assign at_top    = (step_ff >= sweep_top);

   // Line state: loads replace it, ticks advance the sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else if (cmd_pop) begin
         if (!is_tick) begin
            phase_ff <= cmd.phase;
            step_ff  <= cmd.step;
         end else begin
            unique case (phase_ff)
               PH_VERT, PH_HORZ, PH_GENY: begin
                  if (at_top) begin
                     phase_ff <= PH_IDLE;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
               PH_GENX: begin
                  if (at_top) begin
                     phase_ff <= PH_GENY;
                     step_ff  <= y_lo;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
               default: phase_ff <= PH_IDLE;
            endcase
         end
      end
   end

   // Endpoints, colour and the pixel being produced
   always_ff @(posedge clock) begin
      if (cmd_pop && !is_tick) begin
         x0_ff     <= cmd.x_start;
         y0_ff     <= cmd.y_start;
         xn_ff     <= cmd.x_end;
         yn_ff     <= cmd.y_end;
         colour_ff <= cmd.colour;
      end
      if (cmd_pop && is_tick) begin
         case (phase_ff)
            PH_VERT: begin
               px_ff   <= x0_ff;
               py_ff   <= step_ff;
               last_ff <= at_top;
            end
            PH_HORZ: begin
               px_ff   <= step_ff;
               py_ff   <= y0_ff;
               last_ff <= at_top;
            end
            PH_GENX: begin
               px_ff      <= step_ff;
               solve_x_ff <= 1'b0;
               last_ff    <= 1'b0;
            end
            PH_GENY: begin
               py_ff      <= step_ff;
               solve_x_ff <= 1'b1;
               last_ff    <= at_top;
            end
            default: ;
         endcase
      end
      if (state_ff == BK_SETUP) begin
         quo_neg_ff <= prod[2*COORD_W+1] ^ dden[COORD_W];
      end
      if (state_ff == BK_COORD) begin
         if (solve_x_ff) begin
            px_ff <= coord_sum[COORD_W-1:0];
         end else begin
            py_ff <= coord_sum[COORD_W-1:0];
         end
      end
   end

   // Numerator (pos - pbase) * dn and divisor dd, split into sign and magnitude
   assign pos_diff = solve_x_ff ? $signed({1'b0, py_ff} - {1'b0, y0_ff})
                                : $signed({1'b0, px_ff} - {1'b0, x0_ff});
   assign dnum     = solve_x_ff ? $signed({1'b0, xn_ff} - {1'b0, x0_ff})
                                : $signed({1'b0, yn_ff} - {1'b0, y0_ff});
   assign dden     = solve_x_ff ? $signed({1'b0, yn_ff} - {1'b0, y0_ff})
                                : $signed({1'b0, xn_ff} - {1'b0, x0_ff});
   assign prod     = pos_diff * dnum;
   assign prod_mag = prod[2*COORD_W+1] ? (2*COORD_W+2)'(-prod) : (2*COORD_W+2)'(prod);
   assign den_mag  = dden[COORD_W] ? (COORD_W+1)'(-dden) : (COORD_W+1)'(dden);

   fbl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[NUM_W-1:0]),
      .divisor  (den_mag[DEN_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Truncated quotient, signed, added to the base endpoint
   assign q_signed   = quo_neg_ff ? (COORD_W+2)'(-{1'b0, div_quo[COORD_W:0]})
                                  : {1'b0, div_quo[COORD_W:0]};
   assign coord_base = solve_x_ff ? x0_ff : y0_ff;
   assign coord_sum  = {2'b00, coord_base} + q_signed;

   // Mirrored-x byte address, wrapping at 32 bits
   assign pix_offset = SCREEN_W32 - {{(ADDR_W-COORD_W){1'b0}}, px_ff}
                     + {{(ADDR_W-COORD_W){1'b0}}, py_ff} * SCREEN_W32;
   assign pix_addr   = frame_base + pix_offset * PIXEL_B32;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_addr_ff   <= pix_addr;
         rsp_colour_ff <= colour_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_colour_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
